@@ rtl/jbp_pkg.sv @@
// ----------------------------------------------------------------------------
// jbp_pkg
// Shared types and constants for the JPEG bit packer with 0xFF/0x00 stuffing.
// ----------------------------------------------------------------------------
package jbp_pkg;

  // Command codes on the input channel
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Width of the chunk data field; hard upper bound on a chunk length
  localparam int unsigned DATA_WIDTH = 16;

  // Marker byte that gets a stuffed zero after it
  localparam logic [7:0] STUFF_MARK = 8'hFF;
  localparam logic [7:0] STUFF_ZERO = 8'h00;

  // One byte job handed from the front to the back: one or two data bytes
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
  } job_t;

endpackage

@@ rtl/jbp_front.sv @@
// ----------------------------------------------------------------------------
// jbp_front
// Accepts chunk and flush items, keeps the bit accumulator and produces
// byte jobs (one or two whole bytes) for the back end.
// ----------------------------------------------------------------------------
module jbp_front import jbp_pkg::*; #(
  parameter int MAX_CHUNK_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        command,
  input  logic [15:0] chunk_bits,
  input  logic [4:0]  chunk_length,
  output logic        job_wr,
  output job_t        job
);

  localparam int LEN_LIMIT = (MAX_CHUNK_BITS < DATA_WIDTH) ? MAX_CHUNK_BITS : DATA_WIDTH;

  // Pending bits, left aligned; fewer than 16 between items
  logic [15:0] acc_r, acc_nxt;
  logic [3:0]  pend_r, pend_nxt;

  logic [4:0]  len_sat;
  logic [15:0] masked;
  logic [4:0]  cnt;
  logic [47:0] placed;
  logic [31:0] merged;
  logic [2:0]  rem;

  // Length saturation and masking of stray bits
  assign len_sat = (chunk_length > 5'(LEN_LIMIT)) ? 5'(LEN_LIMIT) : chunk_length;
  assign masked  = chunk_bits & ~(16'hFFFF << len_sat);
  assign cnt     = 5'(pend_r) + len_sat;
  assign placed  = {masked, 32'd0} >> cnt;
  assign merged  = {acc_r, 16'd0} | placed[31:0];
  assign rem     = pend_r[2:0];

  // Next state and job build
  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    job_wr    = 1'b0;
    job.byte0 = merged[31:24];
    job.byte1 = merged[23:16];
    job.two   = 1'b1;
    if (accept) begin
      unique case (command)
        CMD_APPEND: begin
          if (cnt[4]) begin
            job_wr   = 1'b1;
            acc_nxt  = merged[15:0];
          end else begin
            acc_nxt  = merged[31:16];
          end
          pend_nxt = cnt[3:0];
        end
        CMD_FLUSH: begin
          acc_nxt  = '0;
          pend_nxt = '0;
          if (pend_r[3]) begin
            // whole byte first, then a padded partial byte if bits remain
            job_wr    = 1'b1;
            job.byte0 = acc_r[15:8];
            job.byte1 = acc_r[7:0] | (8'hFF >> rem);
            job.two   = (rem != 3'd0);
          end else if (rem != 3'd0) begin
            job_wr    = 1'b1;
            job.byte0 = acc_r[15:8] | (8'hFF >> rem);
            job.two   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // A flush always leaves the accumulator empty
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && command == CMD_FLUSH) |=> (pend_r == 4'd0 && acc_r == 16'd0))
    else $error("flush did not clear the accumulator");

endmodule

@@ rtl/jbp_queue.sv @@
// ----------------------------------------------------------------------------
// jbp_queue
// Small job queue between the front and the back; decouples their stalls.
// ----------------------------------------------------------------------------
module jbp_queue import jbp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("job written into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");

endmodule

@@ rtl/jbp_back.sv @@
// ----------------------------------------------------------------------------
// jbp_back
// Walks each queued job one byte per cycle while the output register is free
// or popped, inserts a zero after every 0xFF and holds the result there.
// ----------------------------------------------------------------------------
module jbp_back import jbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_done,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_is_last
);

  // Step within a job
  localparam logic [1:0] ST_B0 = 2'd0;
  localparam logic [1:0] ST_S0 = 2'd1;
  localparam logic [1:0] ST_B1 = 2'd2;
  localparam logic [1:0] ST_S1 = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load, step;
  logic [7:0] sel_byte;
  logic       sel_last;

  assign load  = !out_valid_r || pop;
  assign step  = load && job_valid;

  // Byte selection and next step
  always_comb begin
    sel_byte = STUFF_ZERO;
    sel_last = 1'b0;
    st_nxt   = st_r;
    unique case (st_r)
      ST_B0: begin
        sel_byte = job.byte0;
        if (job.byte0 == STUFF_MARK) begin
          st_nxt = ST_S0;
        end else if (job.two) begin
          st_nxt = ST_B1;
        end else begin
          st_nxt   = ST_B0;
          sel_last = 1'b1;
        end
      end
      ST_S0: begin
        if (job.two) begin
          st_nxt = ST_B1;
        end else begin
          st_nxt   = ST_B0;
          sel_last = 1'b1;
        end
      end
      ST_B1: begin
        sel_byte = job.byte1;
        if (job.byte1 == STUFF_MARK) begin
          st_nxt = ST_S1;
        end else begin
          st_nxt   = ST_B0;
          sel_last = 1'b1;
        end
      end
      ST_S1: begin
        st_nxt   = ST_B0;
        sel_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign job_done = step && sel_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_B0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        st_r <= st_nxt;
      end
      if (load) begin
        out_valid_r <= job_valid;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= sel_byte;
      out_last_r <= sel_last;
    end
  end

  assign empty       = !out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;

  // A marker byte is always followed by its stuffed zero in the same job
  a_ff_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && sel_byte == STUFF_MARK) |-> !sel_last)
    else $error("0xFF closed a job without a stuffed zero");

  // Mid-job steps need the job to stay at the queue head
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_B0) |-> job_valid)
    else $error("job left the queue before it finished");

endmodule

@@ rtl/jpeg_bit_packer_byte_stuffing_core.sv @@
// ----------------------------------------------------------------------------
// jpeg_bit_packer_byte_stuffing_core
// JPEG entropy bit writer: packs MSB-first bit chunks into bytes and stuffs
// a 0x00 after every 0xFF byte.
//
// Usage:
//   Input queue: drive in_command / in_chunk_bits / in_chunk_length with push;
//   a transfer happens when push is high and full is low. An append adds up
//   to 16 bits; a flush emits pending whole bytes and a one-padded last byte.
//   Result queue: while empty is low, out_byte / out_is_last show the oldest
//   byte; a transfer happens when pop is high. out_is_last marks the final
//   byte caused by one input item. Items that cause no bytes give no results.
//   The first byte of an item passes the job queue, then the output register.
//   Throughput: one input item per cycle while full is low, into a
//   FIFO_DEPTH-entry job queue; the output side moves one byte per cycle
//   while pop keeps up, and an item makes up to two bytes, four with stuffing.
//   Reset (synchronous, rst_n low) clears the accumulator, the queue and the
//   output valid flag. When the receiver stalls, bytes wait in the output
//   register and jobs in the queue; full rises once the queue fills.
// ----------------------------------------------------------------------------
module jpeg_bit_packer_byte_stuffing_core import jbp_pkg::*; #(
  parameter int MAX_CHUNK_BITS = 16,
  parameter int FIFO_DEPTH     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic [15:0] in_chunk_bits,
  input  logic [4:0]  in_chunk_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_is_last
);

  logic accept;
  logic job_wr;
  job_t job_in;
  logic job_valid;
  job_t job_head;
  logic job_done;

  assign accept = push && !full;

  // Front: accumulator and byte job build
  jbp_front #(
    .MAX_CHUNK_BITS(MAX_CHUNK_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_command),
    .chunk_bits   (in_chunk_bits),
    .chunk_length (in_chunk_length),
    .job_wr       (job_wr),
    .job          (job_in)
  );

  // Job queue
  jbp_queue #(
    .DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_wr),
    .wr_data  (job_in),
    .full     (full),
    .rd_en    (job_done),
    .rd_valid (job_valid),
    .rd_data  (job_head)
  );

  // Back: byte emission with stuffing
  jbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job         (job_head),
    .job_done    (job_done),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .out_is_last (out_is_last)
  );

endmodule
